// ===== design/trapezoidal_velocity_profiler_top_defines.svh =====
// ----------------------------------------------------------------------------
// trapezoidal velocity profiler assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef TRAPEZOIDAL_VELOCITY_PROFILER_TOP_DEFINES_SVH
`define TRAPEZOIDAL_VELOCITY_PROFILER_TOP_DEFINES_SVH

// same-cycle implication, clocked on aclk, off during reset
`define TVP_CHECK_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on aclk, off during reset
`define TVP_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/tvp_pkg.sv =====
// ----------------------------------------------------------------------------
// tvp_pkg
// shared constants, command codes and helpers of the velocity profiler
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tvp_pkg;

    localparam int FRAC_BITS_DEF = 16;

    // configuration port
    localparam int CFG_AW = 2;
    localparam int CFG_DW = 32;
    localparam logic [CFG_AW-1:0] REG_TARGET  = 2'd0;
    localparam logic [CFG_AW-1:0] REG_MAX_VEL = 2'd1;
    localparam logic [CFG_AW-1:0] REG_ACCEL   = 2'd2;
    localparam logic [CFG_AW-1:0] REG_TICK    = 2'd3;

    localparam logic [30:0] MAX_VEL_RST = 31'd65536;
    localparam logic [30:0] ACCEL_RST   = 31'd65536;
    localparam logic [15:0] TICK_RST    = 16'd655;

    // profile phases
    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_ACCEL  = 3'd1;
    localparam logic [2:0] PH_CRUISE = 3'd2;
    localparam logic [2:0] PH_DECEL  = 3'd3;
    localparam logic [2:0] PH_DONE   = 3'd4;

    // datapath operations
    localparam logic [3:0] OP_NOP        = 4'd0;
    localparam logic [3:0] OP_START      = 4'd1;
    localparam logic [3:0] OP_TICK       = 4'd2;
    localparam logic [3:0] OP_CMP1       = 4'd3;
    localparam logic [3:0] OP_CMP2       = 4'd4;
    localparam logic [3:0] OP_SHAPE      = 4'd5;
    localparam logic [3:0] OP_RAMP_TRAP  = 4'd6;
    localparam logic [3:0] OP_TOTAL_TRAP = 4'd7;
    localparam logic [3:0] OP_RAMP_TRI   = 4'd8;
    localparam logic [3:0] OP_PEAK_TRI   = 4'd9;
    localparam logic [3:0] OP_CLASS      = 4'd10;
    localparam logic [3:0] OP_MUL1       = 4'd11;
    localparam logic [3:0] OP_MUL1W      = 4'd12;
    localparam logic [3:0] OP_MUL2       = 4'd13;
    localparam logic [3:0] OP_COV        = 4'd14;
    localparam logic [3:0] OP_POS        = 4'd15;

    typedef struct packed {
        logic [3:0] op;
        logic       iter_start;
        logic       iter_sqrt;
        logic       div_second;
    } cmd_t;

    typedef struct packed {
        logic trap;
        logic iter_done;
    } status_t;

    // clamp an unsigned value to 2^31-1
    function automatic logic [30:0] cap31(input logic [63:0] x);
        logic [30:0] r;
        r = (x > 64'h0000_0000_7FFF_FFFF) ? 31'h7FFF_FFFF : x[30:0];
        return r;
    endfunction

endpackage

// ===== design/tvp_iter.sv =====
// ----------------------------------------------------------------------------
// tvp_iter
// shared restoring divider and integer square root, one bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tvp_iter #(
    parameter int FRAC_BITS = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic                    sqrt_mode,
    input  logic [32+FRAC_BITS-1:0] dividend,
    input  logic [30:0]             divisor,
    input  logic [63:0]             radicand,
    output logic                    done,
    output logic [32+FRAC_BITS-1:0] quot,
    output logic [31:0]             root
);
    localparam int DVW = 32 + FRAC_BITS;
    localparam int CW  = $clog2(DVW);

    logic          busy_reg;
    logic          done_reg;
    logic          mode_reg;
    logic [CW-1:0] cnt_reg;
    logic [DVW-1:0] num_reg;
    logic [30:0]   rem_reg;
    logic [30:0]   den_reg;
    logic [63:0]   x_reg;
    logic [63:0]   r_reg;
    logic [63:0]   b_reg;

    logic [31:0]   rem_sh;
    logic          div_ge;
    logic [31:0]   rem_new;
    logic [63:0]   sq_trial;
    logic          sq_ge;

    // one restoring step of each kind
    always_comb begin
        rem_sh   = {rem_reg, num_reg[DVW-1]};
        div_ge   = rem_sh >= {1'b0, den_reg};
        rem_new  = div_ge ? (rem_sh - {1'b0, den_reg}) : rem_sh;
        sq_trial = r_reg + b_reg;
        sq_ge    = x_reg >= sq_trial;
    end

    // sequencing
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == '0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // operand and result registers
    always_ff @(posedge aclk) begin
        if (start) begin
            mode_reg <= sqrt_mode;
            cnt_reg  <= sqrt_mode ? CW'(31) : CW'(DVW - 1);
            num_reg  <= dividend;
            rem_reg  <= '0;
            den_reg  <= divisor;
            x_reg    <= radicand;
            r_reg    <= '0;
            b_reg    <= 64'h4000_0000_0000_0000;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - CW'(1);
            if (mode_reg) begin
                if (sq_ge) begin
                    x_reg <= x_reg - sq_trial;
                    r_reg <= (r_reg >> 1) + b_reg;
                end else begin
                    r_reg <= r_reg >> 1;
                end
                b_reg <= b_reg >> 2;
            end else begin
                rem_reg <= rem_new[30:0];
                num_reg <= {num_reg[DVW-2:0], div_ge};
            end
        end
    end

    assign done = done_reg;
    assign quot = num_reg;
    assign root = r_reg[31:0];

endmodule

// ===== design/tvp_ctrl.sv =====
// ----------------------------------------------------------------------------
// tvp_ctrl
// sequencer of the profiler: steps the datapath through start and sample work
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tvp_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    input  logic             s_kind,
    output logic             s_tready,
    input  logic             m_tready,
    output logic             m_tvalid,
    output tvp_pkg::cmd_t    cmd,
    input  tvp_pkg::status_t status
);
    import tvp_pkg::*;

    localparam logic [4:0] ST_IDLE       = 5'd0;
    localparam logic [4:0] ST_CMP1       = 5'd1;
    localparam logic [4:0] ST_CMP2       = 5'd2;
    localparam logic [4:0] ST_SHAPE      = 5'd3;
    localparam logic [4:0] ST_DIV1       = 5'd4;
    localparam logic [4:0] ST_WAIT1      = 5'd5;
    localparam logic [4:0] ST_RAMP_TRAP  = 5'd6;
    localparam logic [4:0] ST_WAIT2      = 5'd7;
    localparam logic [4:0] ST_TOTAL_TRAP = 5'd8;
    localparam logic [4:0] ST_SQRT       = 5'd9;
    localparam logic [4:0] ST_WAIT3      = 5'd10;
    localparam logic [4:0] ST_RAMP_TRI   = 5'd11;
    localparam logic [4:0] ST_PEAK_TRI   = 5'd12;
    localparam logic [4:0] ST_CLASS      = 5'd13;
    localparam logic [4:0] ST_MUL1       = 5'd14;
    localparam logic [4:0] ST_MUL1W      = 5'd15;
    localparam logic [4:0] ST_MUL2       = 5'd16;
    localparam logic [4:0] ST_COV        = 5'd17;
    localparam logic [4:0] ST_POS        = 5'd18;

    logic [4:0] state_reg, state_next;
    logic       mvalid_reg, mvalid_next;

    // next state and commands
    always_comb begin
        state_next  = state_reg;
        mvalid_next = mvalid_reg && !m_tready;
        cmd         = '0;
        cmd.op      = OP_NOP;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.op     = s_kind ? OP_TICK : OP_START;
                    state_next = s_kind ? ST_CLASS : ST_CMP1;
                end
            end
            ST_CMP1: begin
                cmd.op     = OP_CMP1;
                state_next = ST_CMP2;
            end
            ST_CMP2: begin
                cmd.op     = OP_CMP2;
                state_next = ST_SHAPE;
            end
            ST_SHAPE: begin
                cmd.op     = OP_SHAPE;
                state_next = ST_DIV1;
            end
            ST_DIV1: begin
                cmd.iter_start = 1'b1;
                state_next     = ST_WAIT1;
            end
            ST_WAIT1: begin
                if (status.iter_done) begin
                    state_next = status.trap ? ST_RAMP_TRAP : ST_SQRT;
                end
            end
            ST_RAMP_TRAP: begin
                cmd.op         = OP_RAMP_TRAP;
                cmd.iter_start = 1'b1;
                cmd.div_second = 1'b1;
                state_next     = ST_WAIT2;
            end
            ST_WAIT2: begin
                if (status.iter_done) begin
                    state_next = ST_TOTAL_TRAP;
                end
            end
            ST_TOTAL_TRAP: begin
                cmd.op     = OP_TOTAL_TRAP;
                state_next = ST_CLASS;
            end
            ST_SQRT: begin
                cmd.iter_start = 1'b1;
                cmd.iter_sqrt  = 1'b1;
                state_next     = ST_WAIT3;
            end
            ST_WAIT3: begin
                if (status.iter_done) begin
                    state_next = ST_RAMP_TRI;
                end
            end
            ST_RAMP_TRI: begin
                cmd.op     = OP_RAMP_TRI;
                state_next = ST_PEAK_TRI;
            end
            ST_PEAK_TRI: begin
                cmd.op     = OP_PEAK_TRI;
                state_next = ST_CLASS;
            end
            ST_CLASS: begin
                cmd.op     = OP_CLASS;
                state_next = ST_MUL1;
            end
            ST_MUL1: begin
                cmd.op     = OP_MUL1;
                state_next = ST_MUL1W;
            end
            ST_MUL1W: begin
                cmd.op     = OP_MUL1W;
                state_next = ST_MUL2;
            end
            ST_MUL2: begin
                cmd.op     = OP_MUL2;
                state_next = ST_COV;
            end
            ST_COV: begin
                cmd.op     = OP_COV;
                state_next = ST_POS;
            end
            ST_POS: begin
                // load the output register once the previous transaction has left
                if (!mvalid_reg || m_tready) begin
                    cmd.op      = OP_POS;
                    mvalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = mvalid_reg;

endmodule

// ===== design/tvp_dp.sv =====
// ----------------------------------------------------------------------------
// tvp_dp
// profiler datapath: configuration, profile state, shared multiplier and
// the divide / square root unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tvp_dp #(
    parameter int FRAC_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [tvp_pkg::CFG_AW-1:0]    cfg_addr,
    input  logic [tvp_pkg::CFG_DW-1:0]    cfg_wdata,
    input  logic [31:0]                   in_pos,
    input  tvp_pkg::cmd_t                 cmd,
    output tvp_pkg::status_t              status,
    output logic [31:0]                   out_vel,
    output logic [31:0]                   out_pos,
    output logic [2:0]                    out_phase,
    output logic                          out_done
);
    import tvp_pkg::*;

    localparam int DVW = 32 + FRAC_BITS;

    // configuration
    logic [31:0] target_reg;
    logic [30:0] max_vel_reg;
    logic [30:0] accel_reg;
    logic [15:0] tick_reg;

    // profile state
    logic        running_reg;
    logic [31:0] elapsed_reg;
    logic [31:0] ramp_reg;
    logic [31:0] total_reg;
    logic [31:0] peak_reg;
    logic [31:0] origin_reg;
    logic [31:0] dist_reg;
    logic [1:0]  sign_reg;

    // working registers
    logic        trap_reg;
    logic [63:0] prod_reg;
    logic [63:0] cmp_reg;
    logic [2:0]  ph_reg;
    logic [31:0] top_reg;
    logic [30:0] v_reg;
    logic [63:0] part_reg;
    logic [31:0] cov_reg;

    logic [30:0]  acc_nz, vm_nz;
    logic [32:0]  dist_s, dist_mag;
    logic [31:0]  mul_x, mul_y;
    logic [63:0]  mul_p;
    logic [DVW-1:0] div_num;
    logic [30:0]  div_den;
    logic [63:0]  q64, rad;
    logic [DVW-1:0] quot;
    logic [31:0]  root;
    logic         iter_done;
    logic [63:0]  tq_wide;
    logic [32:0]  el_sum;
    logic [31:0]  el_next;
    logic [DVW:0] tot_sum;
    logic [31:0]  cruise_end;
    logic [63:0]  sh1, shf, cov_full;
    logic [30:0]  vmag;
    logic [31:0]  vel_val;
    logic signed [33:0] pos_wide;
    logic [31:0]  pos_sat;

    // zero speed or acceleration acts as one
    assign acc_nz = (accel_reg == '0) ? 31'd1 : accel_reg;
    assign vm_nz  = (max_vel_reg == '0) ? 31'd1 : max_vel_reg;

    // signed distance to target on a start transaction
    assign dist_s   = {target_reg[31], target_reg} - {in_pos[31], in_pos};
    assign dist_mag = dist_s[32] ? (33'd0 - dist_s) : dist_s;

    // tick period rescaled from Q0.16 to the working fraction
    assign tq_wide = {24'd0, tick_reg, 24'd0} >> (40 - FRAC_BITS);
    assign el_sum  = {1'b0, elapsed_reg} + {1'b0, tq_wide[31:0]};
    assign el_next = el_sum[32] ? 32'hFFFF_FFFF : el_sum[31:0];

    // shared multiplier operand select
    always_comb begin
        mul_x = '0;
        mul_y = '0;
        case (cmd.op)
            OP_CMP1: begin
                mul_x = dist_reg;
                mul_y = {1'b0, acc_nz};
            end
            OP_CMP2: begin
                mul_x = {1'b0, vm_nz};
                mul_y = {1'b0, vm_nz};
            end
            OP_RAMP_TRI: begin
                mul_x = {1'b0, acc_nz};
                mul_y = root;
            end
            OP_MUL1: begin
                mul_x = (ph_reg == PH_CRUISE) ? peak_reg : {1'b0, acc_nz};
                mul_y = (ph_reg == PH_CRUISE) ? ramp_reg : top_reg;
            end
            OP_MUL2: begin
                mul_x = (ph_reg == PH_CRUISE) ? peak_reg : {1'b0, v_reg};
                mul_y = top_reg;
            end
            default: begin
                mul_x = '0;
                mul_y = '0;
            end
        endcase
    end
    assign mul_p = 64'(mul_x) * 64'(mul_y);

    // divider and root operands
    always_comb begin
        if (cmd.div_second || !trap_reg) begin
            div_num = DVW'(dist_reg) << FRAC_BITS;
        end else begin
            div_num = DVW'(vm_nz) << FRAC_BITS;
        end
        div_den = cmd.div_second ? vm_nz : acc_nz;
        q64     = 64'(quot);
        rad     = ((q64 >> (64 - FRAC_BITS)) != 64'd0) ? '1 : (q64 << FRAC_BITS);
    end

    tvp_iter #(
        .FRAC_BITS (FRAC_BITS)
    ) u_iter (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.iter_start),
        .sqrt_mode (cmd.iter_sqrt),
        .dividend  (div_num),
        .divisor   (div_den),
        .radicand  (rad),
        .done      (iter_done),
        .quot      (quot),
        .root      (root)
    );

    assign tot_sum    = {1'b0, DVW'(ramp_reg)} + {1'b0, quot};
    assign cruise_end = (total_reg > ramp_reg) ? (total_reg - ramp_reg) : 32'd0;

    // covered distance for the current phase
    always_comb begin
        sh1 = prod_reg >> (FRAC_BITS + 1);
        shf = prod_reg >> FRAC_BITS;
        case (ph_reg)
            PH_ACCEL:  cov_full = sh1;
            PH_CRUISE: cov_full = part_reg + shf;
            PH_DECEL:  cov_full = (sh1 > 64'(dist_reg)) ? 64'd0 : (64'(dist_reg) - sh1);
            PH_DONE:   cov_full = 64'(dist_reg);
            default:   cov_full = 64'd0;
        endcase
    end

    // signed velocity and saturated position
    always_comb begin
        vmag = ((ph_reg == PH_ACCEL) || (ph_reg == PH_CRUISE) || (ph_reg == PH_DECEL))
             ? v_reg : 31'd0;
        if (sign_reg == 2'b00) begin
            vel_val  = 32'd0;
            pos_wide = $signed({{2{origin_reg[31]}}, origin_reg});
        end else if (sign_reg[1]) begin
            vel_val  = 32'd0 - {1'b0, vmag};
            pos_wide = $signed({{2{origin_reg[31]}}, origin_reg}) - $signed({2'b00, cov_reg});
        end else begin
            vel_val  = {1'b0, vmag};
            pos_wide = $signed({{2{origin_reg[31]}}, origin_reg}) + $signed({2'b00, cov_reg});
        end
        if (pos_wide > 34'sh0_7FFF_FFFF) begin
            pos_sat = 32'h7FFF_FFFF;
        end else if (pos_wide < -34'sh0_8000_0000) begin
            pos_sat = 32'h8000_0000;
        end else begin
            pos_sat = pos_wide[31:0];
        end
    end

    // configuration and profile state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg  <= '0;
            max_vel_reg <= MAX_VEL_RST;
            accel_reg   <= ACCEL_RST;
            tick_reg    <= TICK_RST;
            running_reg <= 1'b0;
            elapsed_reg <= '0;
            ramp_reg    <= '0;
            total_reg   <= '0;
            peak_reg    <= '0;
            origin_reg  <= '0;
            dist_reg    <= '0;
            sign_reg    <= '0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    REG_TARGET:  target_reg  <= cfg_wdata;
                    REG_MAX_VEL: max_vel_reg <= cfg_wdata[30:0];
                    REG_ACCEL:   accel_reg   <= cfg_wdata[30:0];
                    REG_TICK:    tick_reg    <= cfg_wdata[15:0];
                    default:     target_reg  <= target_reg;
                endcase
            end
            case (cmd.op)
                OP_START: begin
                    origin_reg  <= in_pos;
                    dist_reg    <= dist_mag[31:0];
                    sign_reg    <= (dist_s == 33'd0) ? 2'b00 : (dist_s[32] ? 2'b11 : 2'b01);
                    elapsed_reg <= '0;
                    running_reg <= 1'b1;
                end
                OP_TICK: begin
                    if (running_reg) begin
                        elapsed_reg <= el_next;
                    end
                end
                OP_RAMP_TRAP: begin
                    ramp_reg <= (quot[DVW-1:32] != '0) ? 32'hFFFF_FFFF : quot[31:0];
                    peak_reg <= {1'b0, vm_nz};
                end
                OP_TOTAL_TRAP: begin
                    total_reg <= (tot_sum[DVW:32] != '0) ? 32'hFFFF_FFFF : tot_sum[31:0];
                end
                OP_RAMP_TRI: begin
                    ramp_reg  <= root;
                    total_reg <= root[31] ? 32'hFFFF_FFFF : {root[30:0], 1'b0};
                end
                OP_PEAK_TRI: begin
                    peak_reg <= {1'b0, cap31(prod_reg >> FRAC_BITS)};
                end
                default: begin
                    running_reg <= running_reg;
                end
            endcase
        end
    end

    // working registers and output register
    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_CMP1, OP_RAMP_TRI, OP_MUL1, OP_MUL2: begin
                prod_reg <= mul_p;
            end
            OP_CMP2: begin
                cmp_reg  <= prod_reg;
                prod_reg <= mul_p;
            end
            OP_SHAPE: begin
                trap_reg <= cmp_reg > prod_reg;
            end
            OP_CLASS: begin
                top_reg <= '0;
                if (!running_reg) begin
                    ph_reg <= PH_IDLE;
                end else if (elapsed_reg >= total_reg) begin
                    ph_reg <= PH_DONE;
                end else if (elapsed_reg <= ramp_reg) begin
                    ph_reg  <= PH_ACCEL;
                    top_reg <= elapsed_reg;
                end else if (elapsed_reg <= cruise_end) begin
                    ph_reg  <= PH_CRUISE;
                    top_reg <= elapsed_reg - ramp_reg;
                end else begin
                    ph_reg  <= PH_DECEL;
                    top_reg <= total_reg - elapsed_reg;
                end
            end
            OP_MUL1W: begin
                v_reg    <= (ph_reg == PH_CRUISE) ? peak_reg[30:0]
                                                  : cap31(prod_reg >> FRAC_BITS);
                part_reg <= prod_reg >> (FRAC_BITS + 1);
            end
            OP_COV: begin
                cov_reg <= (cov_full > 64'(dist_reg)) ? dist_reg : cov_full[31:0];
            end
            OP_POS: begin
                out_vel   <= vel_val;
                out_pos   <= pos_sat;
                out_phase <= ph_reg;
                out_done  <= (ph_reg == PH_DONE);
            end
            default: begin
                cov_reg <= cov_reg;
            end
        endcase
    end

    assign status.trap      = trap_reg;
    assign status.iter_done = iter_done;

endmodule

// ===== design/trapezoidal_velocity_profiler_top.sv =====
// A tick transaction passes the class, multiply, covered-distance and position states
// before its result is loaded; the position state waits for the output register to be free.
// A start transaction adds compare, shape and a divide, then a divide (trapezoid) or a
// square root (triangle), in the shared one-bit-per-cycle divide and square root unit.
// One transaction is worked at a time; the next is accepted once the result is loaded.
// Reset (aresetn low, synchronous) restores default registers and an idle profile.
// ----------------------------------------------------------------------------
// trapezoidal_velocity_profiler_top
// trapezoidal / triangular motion profile generator, Q15.16 by default
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module trapezoidal_velocity_profiler_top #(
    parameter int FRAC_BITS = tvp_pkg::FRAC_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // configuration writes
    input  logic                       cfg_we,
    input  logic [tvp_pkg::CFG_AW-1:0] cfg_addr,
    input  logic [tvp_pkg::CFG_DW-1:0] cfg_wdata,
    // input transactions
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [31:0]                s_tdata,  // [31:0] start_position
    input  logic                       s_tuser,  // [0] kind
    // result transactions
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [71:0]                m_tdata   // [31:0] velocity_command,
                                                 // [63:32] position_setpoint,
                                                 // [66:64] phase, [67] done_res
);
    import tvp_pkg::*;

    cmd_t        cmd;
    status_t     status;
    logic [31:0] out_vel;
    logic [31:0] out_pos;
    logic [2:0]  out_phase;
    logic        out_done;

    tvp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_kind   (s_tuser),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .cmd      (cmd),
        .status   (status)
    );

    tvp_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_pos    (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .out_vel   (out_vel),
        .out_pos   (out_pos),
        .out_phase (out_phase),
        .out_done  (out_done)
    );

    // pack the result transaction
    assign m_tdata = {4'd0, out_done, out_phase, out_pos, out_vel};

endmodule

// ===== design/tvp_checker.sv =====
// ----------------------------------------------------------------------------
// tvp_checker
// port-level checks of the profiler result stream
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "trapezoidal_velocity_profiler_top_defines.svh"

module tvp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata
);
    import tvp_pkg::*;

    // a stalled result holds
    `TVP_CHECK_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

    // done comes with the done phase and zero velocity
    `TVP_CHECK_NOW(a_done, m_tvalid && m_tdata[67], (m_tdata[66:64] == PH_DONE) && (m_tdata[31:0] == 32'd0), "done without done phase or with motion")

    // idle phase never moves and is never done
    `TVP_CHECK_NOW(a_idle, m_tvalid && (m_tdata[66:64] == PH_IDLE), (m_tdata[31:0] == 32'd0) && !m_tdata[67], "idle result with motion or done")

    // one transaction at a time: ready drops once an input is taken
    `TVP_CHECK_NEXT(a_busy, s_tvalid && s_tready, !s_tready, "ready held after an input transaction")

endmodule

bind trapezoidal_velocity_profiler_top tvp_checker u_tvp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// trapezoidal velocity profiler testbench
// drives start and tick transactions under several register settings and
// stall patterns, and checks every result against a built-in profile predictor or a table entry
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import tvp_pkg::*;

    localparam int FB = FRAC_BITS_DEF;
    localparam longint unsigned U32_ALL = 64'hFFFF_FFFF;
    localparam longint unsigned S31_ALL = 64'h7FFF_FFFF;
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_TICK  = 1'b1;
    localparam longint CYCLE_LIMIT = 3_000_000;

    typedef struct packed {
        logic [31:0] vel;
        logic [31:0] pos;
        logic [2:0]  ph;
        logic        dn;
    } sample_t;

    typedef struct {
        logic        kind;
        logic [31:0] pos;
        logic        typed;
        sample_t     res;
    } stim_row_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [1:0]  cfg_addr;
    logic [31:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;

    trapezoidal_velocity_profiler_top uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // register mirror
    logic signed [31:0] tgt_pos;
    logic [30:0]        vmax_reg;
    logic [30:0]        accel_reg;
    logic [15:0]        tick_reg;

    // profile state mirror
    longint unsigned t_elapsed, t_ramp, t_total, v_peak, dist_mag;
    longint          org_pos;
    int              dir_sgn;
    bit              prof_running;

    sample_t expected_samples[$];
    int      err_count;
    int      sample_count;
    int      phase_seen[5];
    longint  cycle_count;
    int      src_idle_pct;
    int      snk_idle_pct;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic longint unsigned sat_u32(longint unsigned x);
        return (x > U32_ALL) ? U32_ALL : x;
    endfunction

    function automatic longint unsigned clip_s31(longint unsigned x);
        return (x > S31_ALL) ? S31_ALL : x;
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic sample_t make_sample(longint vel, longint unsigned cov,
                                            logic [2:0] ph, logic dn);
        sample_t s;
        longint p;
        p = org_pos + longint'(dir_sgn) * longint'(cov);
        if (p > 64'sd2147483647) p = 64'sd2147483647;
        if (p < -64'sd2147483648) p = -64'sd2147483648;
        s.vel = vel[31:0];
        s.pos = p[31:0];
        s.ph  = ph;
        s.dn  = dn;
        return s;
    endfunction

    // velocity and setpoint at the current elapsed time
    function automatic sample_t profile_sample();
        longint unsigned a, cruise_end, v, cov, u, back;
        logic [2:0] ph;
        a = (accel_reg == 0) ? 1 : accel_reg;
        cruise_end = (t_total > t_ramp) ? t_total - t_ramp : 0;
        if (!prof_running) return make_sample(0, 0, PH_IDLE, 1'b0);
        if (t_elapsed >= t_total) return make_sample(0, dist_mag, PH_DONE, 1'b1);
        if (t_elapsed <= t_ramp) begin
            v   = clip_s31((a * t_elapsed) >> FB);
            cov = (v * t_elapsed) >> (FB + 1);
            ph  = PH_ACCEL;
        end else if (t_elapsed <= cruise_end) begin
            v   = v_peak;
            cov = ((v_peak * t_ramp) >> (FB + 1)) + ((v_peak * (t_elapsed - t_ramp)) >> FB);
            ph  = PH_CRUISE;
        end else begin
            u    = t_total - t_elapsed;
            v    = clip_s31((a * u) >> FB);
            back = (v * u) >> (FB + 1);
            cov  = (back > dist_mag) ? 0 : dist_mag - back;
            ph   = PH_DECEL;
        end
        if (cov > dist_mag) cov = dist_mag;
        return make_sample(longint'(dir_sgn) * longint'(v), cov, ph, 1'b0);
    endfunction

    // plan a new profile from the start position
    function automatic void plan_profile(logic [31:0] start_pos);
        longint unsigned a, vm, q, rad, rp;
        longint delta;
        a  = (accel_reg == 0) ? 1 : accel_reg;
        vm = (vmax_reg == 0) ? 1 : vmax_reg;
        org_pos  = longint'($signed(start_pos));
        delta    = longint'(tgt_pos) - org_pos;
        dir_sgn  = (delta > 0) ? 1 : ((delta < 0) ? -1 : 0);
        dist_mag = (delta < 0) ? longint'(-delta) : longint'(delta);
        if (dist_mag * a > vm * vm) begin
            rp      = sat_u32((vm << FB) / a);
            t_ramp  = rp;
            t_total = sat_u32(rp + ((dist_mag << FB) / vm));
            v_peak  = vm;
        end else begin
            q   = (dist_mag << FB) / a;
            rad = (q >= (64'd1 << (64 - FB))) ? 64'hFFFF_FFFF_FFFF_FFFF : (q << FB);
            rp  = sat_u32(floor_sqrt(rad));
            t_ramp  = rp;
            t_total = sat_u32(2 * rp);
            v_peak  = clip_s31((a * rp) >> FB);
        end
        t_elapsed    = 0;
        prof_running = 1'b1;
    endfunction

    function automatic sample_t profile_step(logic kind, logic [31:0] pos);
        if (kind == KIND_START) plan_profile(pos);
        else if (prof_running) t_elapsed = sat_u32(t_elapsed + tick_reg);
        return profile_sample();
    endfunction

    // one input transaction, with random sender gaps
    task automatic send_item(logic kind, logic [31:0] pos, logic typed, sample_t typed_res);
        sample_t pred;
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= pos;
        do @(posedge aclk); while (!s_tready);
        pred = profile_step(kind, pos);
        expected_samples.push_back(typed ? typed_res : pred);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_TARGET:  tgt_pos   = val;
            REG_MAX_VEL: vmax_reg  = val[30:0];
            REG_ACCEL:   accel_reg = val[30:0];
            default:     tick_reg  = val[15:0];
        endcase
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        wait (expected_samples.size() == 0);
        repeat (12) @(posedge aclk);
    endtask

    task automatic set_regs(logic [31:0] tg, logic [31:0] vm, logic [31:0] ac,
                            logic [31:0] tk);
        write_reg(REG_TARGET, tg);
        write_reg(REG_MAX_VEL, vm);
        write_reg(REG_ACCEL, ac);
        write_reg(REG_TICK, tk);
    endtask

    // mostly well-formed profiles (start then a run of ticks), some noise
    task automatic random_profiles(int n_items);
        int sent, n_ticks;
        logic [31:0] offs, spos;
        sample_t none;
        none = '0;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(99) < 15) begin
                send_item(logic'($urandom_range(1)), $urandom, 1'b0, none);
                sent++;
            end else begin
                offs = $urandom >> $urandom_range(31);
                spos = $urandom_range(1) ? tgt_pos - offs : tgt_pos + offs;
                send_item(KIND_START, spos, 1'b0, none);
                n_ticks = $urandom_range(3, 40);
                repeat (n_ticks) send_item(KIND_TICK, $urandom, 1'b0, none);
                sent += n_ticks + 1;
            end
        end
    endtask

    // receiver stalls
    always @(posedge aclk) m_tready <= ($urandom_range(99) >= snk_idle_pct);

    // result check
    always @(posedge aclk) begin
        sample_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{vel: m_tdata[31:0], pos: m_tdata[63:32], ph: m_tdata[66:64],
                    dn: m_tdata[67]};
            if (expected_samples.size() == 0) begin
                $error("result transaction with nothing expected");
                err_count++;
            end else begin
                want = expected_samples.pop_front();
                if (got.vel !== want.vel) begin
                    $error("velocity_command: expected %0d, got %0d",
                           $signed(want.vel), $signed(got.vel));
                    err_count++;
                end
                if (got.pos !== want.pos) begin
                    $error("position_setpoint: expected %0d, got %0d",
                           $signed(want.pos), $signed(got.pos));
                    err_count++;
                end
                if (got.ph !== want.ph) begin
                    $error("phase: expected %0d, got %0d", want.ph, got.ph);
                    err_count++;
                end
                if (got.dn !== want.dn) begin
                    $error("done_res: expected %0d, got %0d", want.dn, got.dn);
                    err_count++;
                end
                sample_count++;
                if (want.ph <= PH_DONE) phase_seen[want.ph]++;
            end
        end
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        stim_row_t dir_rows[$];
        sample_t none;
        int k;
        none = '0;
        err_count = 0; sample_count = 0; cycle_count = 0;
        foreach (phase_seen[i]) phase_seen[i] = 0;
        src_idle_pct = 0; snk_idle_pct = 0;
        aresetn = 1'b0; cfg_we = 1'b0; cfg_addr = '0; cfg_wdata = '0;
        s_tvalid = 1'b0; s_tdata = '0; s_tuser = 1'b0; m_tready = 1'b0;
        tgt_pos = 0; vmax_reg = MAX_VEL_RST; accel_reg = ACCEL_RST; tick_reg = TICK_RST;
        t_elapsed = 0; t_ramp = 0; t_total = 0; v_peak = 0; dist_mag = 0;
        org_pos = 0; dir_sgn = 0; prof_running = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table: idle tick, zero distance, extreme start positions
        dir_rows = '{
            '{KIND_TICK,  32'h1234_5678, 1'b1, '{32'd0, 32'd0, PH_IDLE, 1'b0}},
            '{KIND_START, 32'h0000_0000, 1'b1, '{32'd0, 32'd0, PH_DONE, 1'b1}},
            '{KIND_TICK,  32'hFFFF_FFFF, 1'b1, '{32'd0, 32'd0, PH_DONE, 1'b1}},
            '{KIND_START, 32'h8000_0000, 1'b0, none},
            '{KIND_TICK,  32'h0000_0000, 1'b0, none},
            '{KIND_TICK,  32'h0000_0000, 1'b0, none},
            '{KIND_START, 32'h7FFF_FFFF, 1'b0, none},
            '{KIND_TICK,  32'h5555_5555, 1'b0, none},
            '{KIND_TICK,  32'hAAAA_AAAA, 1'b0, none},
            '{KIND_START, 32'h0000_8000, 1'b0, none},
            '{KIND_TICK,  32'h0000_0000, 1'b0, none},
            '{KIND_START, 32'hFFFE_0000, 1'b0, none},
            '{KIND_TICK,  32'h0000_0000, 1'b0, none}
        };
        foreach (dir_rows[i])
            send_item(dir_rows[i].kind, dir_rows[i].pos, dir_rows[i].typed, dir_rows[i].res);
        drain();

        // short profiles through every phase, then the extremes
        for (k = 0; k < 7; k++) begin
            case (k % 4)
                0: begin src_idle_pct = 0;  snk_idle_pct = 0;  end
                1: begin src_idle_pct = 75; snk_idle_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_idle_pct = 75; end
                default: begin src_idle_pct = 10; snk_idle_pct = 10; end
            endcase
            case (k)
                0: set_regs(32'h0005_0000, 32'h0002_0000, 32'h0004_0000, 32'd6554);
                1: set_regs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd65535);
                2: set_regs(32'h8000_0000, 32'd1, 32'd1, 32'd1);
                3: set_regs(32'hFFF0_0000, 32'd0, 32'd0, 32'd20000);
                4: set_regs(32'h0000_0000, 32'hFFFF_FFFF, 32'h0010_0000, 32'hFFFF);
                default: set_regs($urandom, $urandom_range(32'h0100_0000, 1),
                                  $urandom_range(32'h0100_0000, 1), $urandom_range(65535, 1));
            endcase
            random_profiles(110);
            drain();
        end

        $display("checked %0d results; idle %0d, accel %0d, cruise %0d, decel %0d, done %0d",
                 sample_count, phase_seen[0], phase_seen[1], phase_seen[2],
                 phase_seen[3], phase_seen[4]);
        $display("register settings covered defaults, both extremes and zero values");
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
